// ----- hdl/vmps_pkg.sv -----
package vmps_pkg;

   // word field widths
   localparam int ELEM_W     = 16;
   localparam int PROD_W     = 32;
   localparam int SUM_W      = 48;
   localparam int DIM_W      = 11;
   localparam int IDX_OUT_W  = 10;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 64;

   // dimension after reset
   localparam int DIM_RESET = 1024;

   // result queue
   localparam int OUTQ_DEPTH = 4;
   localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);
   localparam int OUTQ_CW    = $clog2(OUTQ_DEPTH + 1);

   typedef struct packed {
      logic first_row;
      logic last_row;
      logic last_col;
   } tag_type;

   typedef struct packed {
      logic s1_busy;
      logic s2_busy;
   } pipe_status_type;

   typedef struct packed {
      logic                 last_column;
      logic [SUM_W-1:0]     column_sum;
      logic [IDX_OUT_W-1:0] column_index;
   } rsp_word_type;

endpackage

// ----- hdl/vmps_ram.sv -----
module vmps_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 1024
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                     wr_data,
   input  logic                                 rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read returns the old contents on a same-address write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/vmps_seq.sv -----
module vmps_seq #(
   parameter int MAX_DIMENSION = 1024
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wen,
   input  logic [vmps_pkg::DIM_W-1:0]            csr_wdata,
   input  logic                                  in_accept,
   output logic [((MAX_DIMENSION > 1) ? $clog2(MAX_DIMENSION) : 1)-1:0] col,
   output vmps_pkg::tag_type                     tag
);

   localparam int IDX_W = (MAX_DIMENSION > 1) ? $clog2(MAX_DIMENSION) : 1;
   localparam int CMP_W = (vmps_pkg::DIM_W > IDX_W + 1) ? vmps_pkg::DIM_W : IDX_W + 1;
   localparam int RESET_DIM = (vmps_pkg::DIM_RESET < MAX_DIMENSION) ?
                              vmps_pkg::DIM_RESET : MAX_DIMENSION;
   localparam logic [IDX_W-1:0] RESET_LAST = IDX_W'(RESET_DIM - 1);

   logic [IDX_W-1:0] col_ff, col_in;
   logic [IDX_W-1:0] row_ff, row_in;
   logic [IDX_W-1:0] last_ff, last_in;
   logic [CMP_W-1:0] wr_dim, clamped, last_wide;

   // out-of-range dimension: zero acts as one, too large acts as the maximum
   always_comb begin
      wr_dim = CMP_W'(csr_wdata);
      if (wr_dim == '0) begin
         clamped = CMP_W'(1);
      end else if (wr_dim > CMP_W'(MAX_DIMENSION)) begin
         clamped = CMP_W'(MAX_DIMENSION);
      end else begin
         clamped = wr_dim;
      end
      last_wide = clamped - CMP_W'(1);
   end

   assign tag.first_row = (row_ff == '0);
   assign tag.last_row  = (row_ff == last_ff);
   assign tag.last_col  = (col_ff == last_ff);
   assign col           = col_ff;

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      last_in = last_ff;
      if (csr_wen) begin
         last_in = last_wide[IDX_W-1:0];
         col_in  = '0;
         row_in  = '0;
      end else if (in_accept) begin
         if (tag.last_col) begin
            col_in = '0;
            row_in = tag.last_row ? '0 : row_ff + IDX_W'(1);
         end else begin
            col_in = col_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         last_ff <= RESET_LAST;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         last_ff <= last_in;
      end
   end

   a_wrap_col: assert property (@(posedge clock) disable iff (reset)
      (in_accept && !csr_wen && tag.last_col) |=> (col_ff == '0))
      else $error("column counter did not wrap after last column");

   a_step_col: assert property (@(posedge clock) disable iff (reset)
      (in_accept && !csr_wen && !tag.last_col) |=>
         (col_ff == $past(col_ff) + IDX_W'(1)) && (row_ff == $past(row_ff)))
      else $error("column counter step wrong");

   a_counters_in_range: assert property (@(posedge clock) disable iff (reset)
      (col_ff <= last_ff) && (row_ff <= last_ff))
      else $error("counter beyond dimension");

endmodule

// ----- hdl/vmps_mac.sv -----
module vmps_mac #(
   parameter int MAX_DIMENSION = 1024
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   in_valid,
   input  logic [((MAX_DIMENSION > 1) ? $clog2(MAX_DIMENSION) : 1)-1:0] in_col,
   input  vmps_pkg::tag_type                      in_tag,
   input  logic signed [vmps_pkg::ELEM_W-1:0]     in_element,
   input  logic signed [vmps_pkg::ELEM_W-1:0]     in_entry,
   output vmps_pkg::pipe_status_type              status,
   output logic                                   out_push,
   output vmps_pkg::rsp_word_type                 out_word
);

   localparam int IDX_W  = (MAX_DIMENSION > 1) ? $clog2(MAX_DIMENSION) : 1;
   localparam int SUM_W  = vmps_pkg::SUM_W;
   localparam int PROD_W = vmps_pkg::PROD_W;

   // stage 1: multiply, memory data arrives
   logic                                s1_valid_ff;
   logic [IDX_W-1:0]                    s1_col_ff;
   vmps_pkg::tag_type                   s1_tag_ff;
   logic signed [vmps_pkg::ELEM_W-1:0]  s1_elem_ff;
   logic signed [vmps_pkg::ELEM_W-1:0]  s1_entry_ff;
   logic signed [PROD_W-1:0]            s1_prod;
   logic [SUM_W-1:0]                    acc_rd;
   logic [SUM_W-1:0]                    acc_fwd;

   // stage 2: accumulate and write back
   logic                                s2_valid_ff;
   logic [IDX_W-1:0]                    s2_col_ff;
   vmps_pkg::tag_type                   s2_tag_ff;
   logic signed [PROD_W-1:0]            s2_prod_ff;
   logic [SUM_W-1:0]                    s2_acc_ff;
   logic [SUM_W-1:0]                    s2_prod_ext;
   logic [SUM_W-1:0]                    s2_sum;

   // last write, missed by the read issued in the same cycle
   logic                                wb_valid_ff;
   logic [IDX_W-1:0]                    wb_col_ff;
   logic [SUM_W-1:0]                    wb_sum_ff;

   logic [IDX_W+vmps_pkg::IDX_OUT_W-1:0] col_wide;

   vmps_ram #(
      .WIDTH (SUM_W),
      .DEPTH (MAX_DIMENSION)
   ) u_acc_ram (
      .clock   (clock),
      .wr_en   (s2_valid_ff),
      .wr_addr (s2_col_ff),
      .wr_data (s2_sum),
      .rd_en   (in_valid),
      .rd_addr (in_col),
      .rd_data (acc_rd)
   );

   assign s1_prod = s1_elem_ff * s1_entry_ff;

   // newest value of the column wins
   always_comb begin
      if (s2_valid_ff && (s2_col_ff == s1_col_ff)) begin
         acc_fwd = s2_sum;
      end else if (wb_valid_ff && (wb_col_ff == s1_col_ff)) begin
         acc_fwd = wb_sum_ff;
      end else begin
         acc_fwd = acc_rd;
      end
   end

   assign s2_prod_ext = {{(SUM_W - PROD_W){s2_prod_ff[PROD_W-1]}}, s2_prod_ff};
   // row 0 overwrites, so a never-written entry is never used
   assign s2_sum = s2_tag_ff.first_row ? s2_prod_ext : (s2_acc_ff + s2_prod_ext);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         wb_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         wb_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid) begin
         s1_col_ff   <= in_col;
         s1_tag_ff   <= in_tag;
         s1_elem_ff  <= in_element;
         s1_entry_ff <= in_entry;
      end
      if (s1_valid_ff) begin
         s2_col_ff  <= s1_col_ff;
         s2_tag_ff  <= s1_tag_ff;
         s2_prod_ff <= s1_prod;
         s2_acc_ff  <= acc_fwd;
      end
      wb_col_ff <= s2_col_ff;
      wb_sum_ff <= s2_sum;
   end

   assign col_wide = (IDX_W + vmps_pkg::IDX_OUT_W)'(s2_col_ff);

   assign status.s1_busy        = s1_valid_ff;
   assign status.s2_busy        = s2_valid_ff;
   assign out_push              = s2_valid_ff && s2_tag_ff.last_row;
   assign out_word.last_column  = s2_tag_ff.last_col;
   assign out_word.column_sum   = s2_sum;
   assign out_word.column_index = col_wide[vmps_pkg::IDX_OUT_W-1:0];

endmodule

// ----- hdl/vmps_outq.sv -----
module vmps_outq (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push,
   input  vmps_pkg::rsp_word_type          push_word,
   input  logic                            pop,
   output logic                            head_valid,
   output vmps_pkg::rsp_word_type          head_word,
   output logic [vmps_pkg::OUTQ_CW-1:0]    used
);

   localparam int AW = vmps_pkg::OUTQ_AW;
   localparam int CW = vmps_pkg::OUTQ_CW;

   vmps_pkg::rsp_word_type slot_ff [vmps_pkg::OUTQ_DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_pop;

   assign head_valid = (count_ff != '0);
   assign head_word  = slot_ff[rd_ptr_ff];
   assign used       = count_ff;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = push   ? wr_ptr_ff + AW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + AW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (!push && do_pop) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_word;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff < CW'(vmps_pkg::OUTQ_DEPTH)) || do_pop)
      else $error("result queue overflow");

endmodule

// ----- hdl/vector_matrix_product_stream_core.sv -----
// Path: a req_ word finishing a column reaches rsp_ via multiply, accumulate, queue.
// Throughput: one req_ word per cycle while the result queue has room for it, set
//    by the one read and one write port of the accumulator memory; a same-column
//    hit is forwarded, never stalled. Reset: synchronous; clears counters,
//    pipeline and result queue; dimension returns to 1024, or MAX_DIMENSION if
//    smaller. The accumulator memory is not cleared: row 0 overwrites it.
module vector_matrix_product_stream_core #(
   parameter int MAX_DIMENSION = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   // config
   input  logic                               csr_wen,
   input  logic [vmps_pkg::DIM_W-1:0]         csr_wdata,   // dimension
   // input words
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [vmps_pkg::REQ_DATA_W-1:0]    req_tdata,   // matrix_element, vector_entry
   // result words
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [vmps_pkg::RSP_DATA_W-1:0]    rsp_tdata,   // column_index, column_sum, pad
   output logic                               rsp_tlast    // last_column
);

   localparam int IDX_W = (MAX_DIMENSION > 1) ? $clog2(MAX_DIMENSION) : 1;
   localparam int CW    = vmps_pkg::OUTQ_CW;

   logic                        req_fire;
   logic [IDX_W-1:0]            col;
   vmps_pkg::tag_type           tag;
   vmps_pkg::pipe_status_type   status;
   logic                        push;
   vmps_pkg::rsp_word_type      push_word;
   vmps_pkg::rsp_word_type      head_word;
   logic [CW-1:0]               used;
   logic [CW:0]                 committed;

   // every word in flight may need a queue slot
   assign committed  = (CW + 1)'(used) + (CW + 1)'(status.s1_busy)
                     + (CW + 1)'(status.s2_busy);
   assign req_tready = (committed < (CW + 1)'(vmps_pkg::OUTQ_DEPTH));
   assign req_fire   = req_tvalid && req_tready;

   vmps_seq #(
      .MAX_DIMENSION (MAX_DIMENSION)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_wdata (csr_wdata),
      .in_accept (req_fire),
      .col       (col),
      .tag       (tag)
   );

   vmps_mac #(
      .MAX_DIMENSION (MAX_DIMENSION)
   ) u_mac (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_fire),
      .in_col     (col),
      .in_tag     (tag),
      .in_element (req_tdata[vmps_pkg::ELEM_W-1:0]),
      .in_entry   (req_tdata[2*vmps_pkg::ELEM_W-1:vmps_pkg::ELEM_W]),
      .status     (status),
      .out_push   (push),
      .out_word   (push_word)
   );

   vmps_outq u_outq (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_word  (push_word),
      .pop        (rsp_tready),
      .head_valid (rsp_tvalid),
      .head_word  (head_word),
      .used       (used)
   );

   assign rsp_tdata = vmps_pkg::RSP_DATA_W'({head_word.column_sum, head_word.column_index});
   assign rsp_tlast = head_word.last_column;

   a_slots_bounded: assert property (@(posedge clock) disable iff (reset)
      committed <= (CW + 1)'(vmps_pkg::OUTQ_DEPTH))
      else $error("more words in flight than result queue slots");

endmodule
